[hw/rtl/cfp_pkg.sv]
// shared types and constants of the command frame parser
// no dependencies

package cfp_pkg;

    localparam int DEFAULT_DEPTH = 16;

    localparam int KIND_W   = 2;
    localparam int STATUS_W = 3;

    typedef logic [KIND_W-1:0]   kind_t;
    typedef logic [STATUS_W-1:0] status_t;
    typedef logic [7:0]          byte_t;

    // item kinds
    localparam kind_t KIND_APPEND  = 2'd0;
    localparam kind_t KIND_PROCESS = 2'd1;
    localparam kind_t KIND_CLEAR   = 2'd2;

    // result status codes
    localparam status_t ST_OK       = 3'd0;
    localparam status_t ST_EMPTY    = 3'd1;
    localparam status_t ST_FORMAT   = 3'd2;
    localparam status_t ST_LENGTH   = 3'd3;
    localparam status_t ST_CHECKSUM = 3'd4;
    localparam status_t ST_INVALID  = 3'd5;
    localparam status_t ST_FULL     = 3'd6;

    // frame symbols and command bytes
    localparam byte_t SYM_START  = 8'h23;
    localparam byte_t SYM_END    = 8'h21;
    localparam byte_t CMD_PARAM  = 8'h50;
    localparam byte_t CMD_STATUS = 8'h53;
    localparam byte_t CMD_RESET  = 8'h52;

endpackage

[hw/rtl/cfp_frame_ram.sv]
// frame byte storage: one write port, one registered read port
// no dependencies

module cfp_frame_ram #(
    parameter int DEPTH  = 16,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [7:0]        wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [7:0]        rd_data
);

    logic [7:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        rd_data <= mem[rd_addr];
    end

endmodule

[hw/rtl/command_frame_parser_unit.sv]
// command frame parser top level: handshakes, scan sequencer, gain registers
// depends on cfp_pkg and cfp_frame_ram
//
// The block collects command bytes in a frame buffer of BUFFER_DEPTH entries and,
// on a process item, parses the frame '#' cmd ... '!'. Every input item gives exactly
// one result transfer carrying a status code, the three gain bytes after the item and
// a report request flag. Append, clear and the unused kind finish without a scan; a
// process item on an empty buffer as well. A process item on a filled buffer reads the
// stored bytes through the single read port of the frame memory, one byte per cycle,
// in a scan state and then checks the frame in an evaluate state before the result
// is set. During that scan the block does not accept input. The checksum of a 'P'
// frame is summed by the same per-byte step as the bytes stream past. A finished
// result sits in an output register; the next item is taken in the cycle that result
// is transferred. The gain outputs show the live gain registers; they only change as
// a process item is evaluated, ahead of its result, so they stay stable with it.

module command_frame_parser_unit #(
    parameter int BUFFER_DEPTH = cfp_pkg::DEFAULT_DEPTH
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    // input item channel
    input  logic                    s_valid,
    output logic                    s_ready,
    input  cfp_pkg::kind_t          s_kind,
    input  logic [7:0]              s_data_byte,
    // result channel
    output logic                    m_valid,
    input  logic                    m_ready,
    output cfp_pkg::status_t        m_status,
    output logic [7:0]              m_gain_p,
    output logic [7:0]              m_gain_i,
    output logic [7:0]              m_gain_d,
    output logic                    m_report_request
);

    import cfp_pkg::*;

    localparam int ADDR_W = $clog2(BUFFER_DEPTH);
    localparam int CNT_W  = $clog2(BUFFER_DEPTH + 1);
    localparam int DIST_W = ADDR_W + 1;

    // sequencer states
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_EVAL = 2'd2;

    // byte offsets after the start mark
    localparam logic [2:0] OFF_CMD  = 3'd1;
    localparam logic [2:0] OFF_P    = 3'd2;
    localparam logic [2:0] OFF_I    = 3'd3;
    localparam logic [2:0] OFF_D    = 3'd4;
    localparam logic [2:0] OFF_SUM  = 3'd5;
    localparam logic [2:0] OFF_DONE = 3'd6;

    logic [1:0]        state_reg;
    logic [CNT_W-1:0]  fill_reg;
    logic [7:0]        gain_p_reg, gain_i_reg, gain_d_reg;
    logic              m_valid_reg;
    status_t           status_reg;
    logic              report_reg;

    // scan bookkeeping
    logic [CNT_W-1:0]  rd_addr_reg;
    logic              pv_reg;
    logic [ADDR_W-1:0] pidx_reg;
    logic              s_found_reg, e_found_reg;
    logic [ADDR_W-1:0] s_idx_reg, e_idx_reg;
    logic [2:0]        off_reg;
    logic [7:0]        cmd_reg, p_reg, i_reg, d_reg, sum_reg, acc_reg;

    logic              accept;
    logic              has_room;
    logic              wr_en;
    logic [7:0]        rd_data;
    logic              has_frame;
    logic              dist6, dist2;

    assign s_ready  = (state_reg == S_IDLE) && (!m_valid_reg || m_ready);
    assign accept   = s_valid && s_ready;
    assign has_room = fill_reg < CNT_W'(BUFFER_DEPTH);
    assign wr_en    = accept && (s_kind == KIND_APPEND) && has_room;

    cfp_frame_ram #(
        .DEPTH  (BUFFER_DEPTH),
        .ADDR_W (ADDR_W)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (fill_reg[ADDR_W-1:0]),
        .wr_data (s_data_byte),
        .rd_addr (rd_addr_reg[ADDR_W-1:0]),
        .rd_data (rd_data)
    );

    // frame checks on the scan results
    assign has_frame = s_found_reg && e_found_reg && (off_reg != OFF_CMD);
    assign dist6 = {1'b0, e_idx_reg} == ({1'b0, s_idx_reg} + DIST_W'(6));
    assign dist2 = {1'b0, e_idx_reg} == ({1'b0, s_idx_reg} + DIST_W'(2));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            fill_reg    <= '0;
            gain_p_reg  <= '0;
            gain_i_reg  <= '0;
            gain_d_reg  <= '0;
            m_valid_reg <= 1'b0;
            pv_reg      <= 1'b0;
        end else begin
            // a new item sets or clears the result valid itself
            if (m_valid_reg && m_ready && !accept) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (accept) begin
                        report_reg <= 1'b0;
                        case (s_kind)
                            KIND_APPEND: begin
                                m_valid_reg <= 1'b1;
                                if (has_room) begin
                                    fill_reg   <= fill_reg + CNT_W'(1);
                                    status_reg <= ST_OK;
                                end else begin
                                    status_reg <= ST_FULL;
                                end
                            end
                            KIND_PROCESS: begin
                                if (fill_reg == '0) begin
                                    m_valid_reg <= 1'b1;
                                    status_reg  <= ST_EMPTY;
                                end else begin
                                    // start a scan from address zero
                                    state_reg   <= S_SCAN;
                                    m_valid_reg <= 1'b0;
                                    rd_addr_reg <= '0;
                                    pv_reg      <= 1'b0;
                                    s_found_reg <= 1'b0;
                                    e_found_reg <= 1'b0;
                                    off_reg     <= OFF_CMD;
                                end
                            end
                            KIND_CLEAR: begin
                                fill_reg    <= '0;
                                m_valid_reg <= 1'b1;
                                status_reg  <= ST_OK;
                            end
                            default: begin
                                m_valid_reg <= 1'b1;
                                status_reg  <= ST_OK;
                            end
                        endcase
                    end
                end
                S_SCAN: begin
                    // issue one read per cycle, data comes back in the next cycle
                    if (rd_addr_reg != fill_reg) begin
                        rd_addr_reg <= rd_addr_reg + CNT_W'(1);
                        pv_reg      <= 1'b1;
                    end else begin
                        pv_reg    <= 1'b0;
                        state_reg <= S_EVAL;
                    end
                    pidx_reg <= rd_addr_reg[ADDR_W-1:0];
                    if (pv_reg) begin
                        if (!s_found_reg && rd_data == SYM_START) begin
                            s_found_reg <= 1'b1;
                            s_idx_reg   <= pidx_reg;
                            off_reg     <= OFF_CMD;
                            acc_reg     <= '0;
                        end else if (s_found_reg && off_reg != OFF_DONE) begin
                            off_reg <= off_reg + 3'd1;
                            case (off_reg)
                                OFF_CMD: begin
                                    cmd_reg <= rd_data;
                                    acc_reg <= acc_reg + rd_data;
                                end
                                OFF_P: begin
                                    p_reg   <= rd_data;
                                    acc_reg <= acc_reg + rd_data;
                                end
                                OFF_I: begin
                                    i_reg   <= rd_data;
                                    acc_reg <= acc_reg + rd_data;
                                end
                                OFF_D: begin
                                    d_reg   <= rd_data;
                                    acc_reg <= acc_reg + rd_data;
                                end
                                OFF_SUM: begin
                                    sum_reg <= rd_data;
                                end
                                default: begin
                                    sum_reg <= sum_reg;
                                end
                            endcase
                        end
                        if (!e_found_reg && rd_data == SYM_END) begin
                            e_found_reg <= 1'b1;
                            e_idx_reg   <= pidx_reg;
                        end
                    end
                end
                S_EVAL: begin
                    state_reg   <= S_IDLE;
                    m_valid_reg <= 1'b1;
                    if (!has_frame) begin
                        // missing mark or no command byte, buffer kept
                        status_reg <= ST_FORMAT;
                    end else if (cmd_reg == CMD_PARAM) begin
                        fill_reg <= '0;
                        if (!dist6) begin
                            status_reg <= ST_LENGTH;
                        end else if (acc_reg != sum_reg) begin
                            status_reg <= ST_CHECKSUM;
                        end else begin
                            status_reg <= ST_OK;
                            gain_p_reg <= p_reg;
                            gain_i_reg <= i_reg;
                            gain_d_reg <= d_reg;
                        end
                    end else if (cmd_reg == CMD_STATUS || cmd_reg == CMD_RESET) begin
                        fill_reg <= '0;
                        if (!dist2) begin
                            status_reg <= ST_LENGTH;
                        end else begin
                            status_reg <= ST_OK;
                            if (cmd_reg == CMD_STATUS) begin
                                report_reg <= 1'b1;
                            end else begin
                                gain_p_reg <= '0;
                                gain_i_reg <= '0;
                                gain_d_reg <= '0;
                            end
                        end
                    end else begin
                        // unknown command, buffer kept
                        status_reg <= ST_INVALID;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_status         = status_reg;
    assign m_gain_p         = gain_p_reg;
    assign m_gain_i         = gain_i_reg;
    assign m_gain_d         = gain_d_reg;
    assign m_report_request = report_reg;

endmodule
